// ----- rtl/core/zpwg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the zero-padded window gather core.
// No dependencies; imported by the controller, the datapath and the top level.

package zpwg_pkg;

    // Frame geometry; MAX_WIDTH is a power of two so that an address is {row, column}
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int RADIUS     = 1;

    localparam int SIDE      = 2 * RADIUS + 1;
    localparam int NUM_TAPS  = SIDE * SIDE;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Signed window offset, -RADIUS..RADIUS
    localparam int OFF_W = $clog2(SIDE) + 1;
    localparam logic signed [OFF_W-1:0] OFF_MIN = OFF_W'(-RADIUS);
    localparam logic signed [OFF_W-1:0] OFF_MAX = OFF_W'(RADIUS);

    // Field widths
    localparam int PIX_W  = 8;
    localparam int POS_W  = 8;
    localparam int TAP_W  = 6;
    localparam int VAL_W  = 2 * PIX_W;
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 2;

    localparam logic [TAP_W-1:0] LAST_TAP_IDX = TAP_W'(NUM_TAPS - 1);
    localparam logic [CFG_W-1:0] MAX_WIDTH_C  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_HEIGHT_C = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(256);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(256);

    // Operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_GATHER = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

    typedef struct packed {
        logic             opcode;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] pixel;
    } zpwg_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] tap_value;
        logic [TAP_W-1:0] tap_index;
        logic             last_tap;
    } zpwg_out_t;

    // Controller to datapath
    typedef struct packed {
        logic store;   // write the accepted pixel
        logic load;    // capture a window centre and rewind the tap counters
        logic issue;   // read one tap and advance
    } zpwg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;  // the tap being issued is the final one
    } zpwg_status_t;

endpackage

// ----- rtl/core/zpwg_ctrl.sv -----
`timescale 1ns / 1ps
// Transaction controller of the window gather core: accepts commands, sequences taps.
// Depends on zpwg_pkg.

module zpwg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  opcode,
    input  zpwg_pkg::zpwg_status_t dp_status,
    output zpwg_pkg::zpwg_cmd_t    dp_cmd,
    output logic                  busy
);
    import zpwg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_GATHER)
                    begin
                        dp_cmd.load = 1'b1;
                        state_next  = ST_ISSUE;
                    end
                    else
                    begin
                        dp_cmd.store = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                dp_cmd.issue = 1'b1;
                if (dp_status.last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/zpwg_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the window gather core: frame memory, frame size registers,
// window offset counters and the tap output stage. Depends on zpwg_pkg.

module zpwg_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  zpwg_pkg::zpwg_cmd_t      dp_cmd,
    input  zpwg_pkg::zpwg_in_t       item,
    input  logic                    cfg_we,
    input  logic [zpwg_pkg::IDX_W-1:0] cfg_index,
    input  logic [zpwg_pkg::CFG_W-1:0] cfg_data,
    output zpwg_pkg::zpwg_status_t   dp_status,
    output logic                    result_valid,
    output zpwg_pkg::zpwg_out_t      result
);
    import zpwg_pkg::*;

    localparam int X_W = POS_W + 2;

    logic [CFG_W-1:0]        width_reg;
    logic [CFG_W-1:0]        height_reg;
    logic [CFG_W-1:0]        eff_width;
    logic [CFG_W-1:0]        eff_height;

    logic [POS_W-1:0]        cx_reg;
    logic [POS_W-1:0]        cy_reg;
    logic signed [OFF_W-1:0] dx_reg;
    logic signed [OFF_W-1:0] dy_reg;
    logic [TAP_W-1:0]        tap_reg;

    logic signed [X_W-1:0]   x_pos;
    logic signed [X_W-1:0]   y_pos;
    logic                    hit;
    logic                    wr_hit;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;

    logic [PIX_W-1:0]        frame_mem [MEM_DEPTH];
    logic [PIX_W-1:0]        rd_pix_reg;
    logic                    valid_reg;
    logic                    hit_reg;
    logic [TAP_W-1:0]        idx_reg;
    logic                    last_reg;

    // Frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Clamp the stored frame size to the maximum frame size
    assign eff_width  = (width_reg  > MAX_WIDTH_C)  ? MAX_WIDTH_C  : width_reg;
    assign eff_height = (height_reg > MAX_HEIGHT_C) ? MAX_HEIGHT_C : height_reg;

    // Window centre and offset counters, dx inner, dy outer
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cx_reg  <= item.column;
            cy_reg  <= item.row;
            dx_reg  <= OFF_MIN;
            dy_reg  <= OFF_MIN;
            tap_reg <= '0;
        end
        else if (dp_cmd.issue)
        begin
            tap_reg <= tap_reg + TAP_W'(1);
            if (dx_reg == OFF_MAX)
            begin
                dx_reg <= OFF_MIN;
                dy_reg <= dy_reg + OFF_W'(1);
            end
            else
            begin
                dx_reg <= dx_reg + OFF_W'(1);
            end
        end
    end

    assign x_pos = $signed({2'b00, cx_reg}) + X_W'(dx_reg);
    assign y_pos = $signed({2'b00, cy_reg}) + X_W'(dy_reg);

    assign hit = !x_pos[X_W-1] && !y_pos[X_W-1]
              && (x_pos[CFG_W-1:0] < eff_width)
              && (y_pos[CFG_W-1:0] < eff_height);

    assign wr_hit = ({1'b0, item.column} < eff_width) && ({1'b0, item.row} < eff_height);

    assign rd_addr = {y_pos[ROW_W-1:0], x_pos[COL_W-1:0]};
    assign wr_addr = {item.row[ROW_W-1:0], item.column[COL_W-1:0]};

    assign dp_status.last_issue = (tap_reg == LAST_TAP_IDX);

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.store && wr_hit)
        begin
            frame_mem[wr_addr] <= item.pixel;
        end
        rd_pix_reg <= frame_mem[rd_addr];
    end

    // Tap tags travel alongside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dp_cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit;
        idx_reg  <= tap_reg;
        last_reg <= dp_status.last_issue;
    end

    // pixel * 257 is the byte repeated
    assign result_valid     = valid_reg;
    assign result.tap_value = hit_reg ? {rd_pix_reg, rd_pix_reg} : '0;
    assign result.tap_index = idx_reg;
    assign result.last_tap  = last_reg;

endmodule

// ----- rtl/core/zero_padded_window_gather_core.sv -----
`timescale 1ns / 1ps
// Zero-padded window gather: a pixel store is written at the accepting edge (busy stays low).
// A window request gives (2*RADIUS+1)^2 taps, one per cycle, nine at radius 1; the window
// centre is loaded at the accepting edge, then each tap passes the registered memory read; no stalls.
// A new transaction is taken in the cycle the last tap is shown; no request is taken while busy.
// Reset is asynchronous, active low: frame size returns to 256 x 256, frame contents are kept.

module zero_padded_window_gather_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  zpwg_pkg::zpwg_in_t          cmd,
    input  logic                       cfg_we,
    input  logic [zpwg_pkg::IDX_W-1:0] cfg_index,
    input  logic [zpwg_pkg::CFG_W-1:0] cfg_data,
    output logic                       result_valid,
    output zpwg_pkg::zpwg_out_t         result
);
    import zpwg_pkg::*;

    zpwg_cmd_t    dp_cmd;
    zpwg_status_t dp_status;

    // Controller: decides store versus gather and paces the tap sequence
    zpwg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (cmd.opcode),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy)
    );

    // Datapath: frame memory, offset counters and the tap output register
    zpwg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .item         (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Taps of one window come out back to back
    a_taps_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_tap |=> result_valid)
        else $error("tap stream broke before the last tap");

    // Tap index advances by one within a window
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_tap |=>
            result.tap_index == $past(result.tap_index) + TAP_W'(1))
        else $error("tap index did not advance by one");

    // The final tap carries the last index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_tap |-> result.tap_index == LAST_TAP_IDX)
        else $error("last tap marked at the wrong index");

    // A gather holds busy on the following cycle
    a_gather_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.opcode == OP_GATHER |=> busy)
        else $error("gather accepted without going busy");

    // Nothing follows the last tap straight away
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_tap |=> !result_valid)
        else $error("tap emitted straight after the last tap");
`endif

endmodule
